// ===== rtl/annexb_start_code_deframer_top_macros.svh =====
// assertion macros for the annex b start code deframer
`ifndef ANNEXB_START_CODE_DEFRAMER_TOP_MACROS_SVH
`define ANNEXB_START_CODE_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTH
`define ABDF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
`define ABDF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define ABDF_ASSERT_IMP(name, ante, cons)
`define ABDF_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== rtl/abdf_pkg.sv =====
// shared types and constants for the annex b start code deframer
package abdf_pkg;

  // saturation limit of the unit length counter
  localparam int LENGTH_BITS = 32;
  localparam logic [31:0] LEN_MAX = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << LENGTH_BITS) - 64'd1);

  // command queue geometry
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_UNIT_END = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_e;

  // at most one command per byte: held zeros, the byte itself, unit ends or an error
  typedef struct packed {
    logic [1:0] zeros;
    logic       has_byte;
    logic [7:0] data;
    logic [1:0] ends;
    logic       err;
  } abdf_cmd_t;

endpackage

// ===== rtl/annexb_start_code_deframer_top.sv =====
// annex b start code deframer: one input byte per cycle in while not full, result words out
// path: a byte's command is stored in the command queue, then each word in the output word register
// throughput: one byte per cycle while the command queue is not full; a byte that
//   yields k words (k up to 4) holds the back end until all k are emitted, a 4-deep command queue absorbs it
// reset: asynchronous, clears the phase, queue, length counter and output valid flag; no clearing pass
`include "annexb_start_code_deframer_top_macros.svh"
module annexb_start_code_deframer_top import abdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        first_of_unit_o,
  output logic [31:0] unit_length_o,
  output logic        last_of_run_o
);

  logic      accept;
  logic      fr_valid;
  abdf_cmd_t fr_cmd;
  logic      q_valid;
  abdf_cmd_t q_cmd;
  logic      q_pop;
  logic      out_payload;
  logic      end_popped;

  assign accept = push && !full;

  // front: byte classification
  abdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .stream_end_i (stream_end_i),
    .cmd_valid_o  (fr_valid),
    .cmd_o        (fr_cmd)
  );

  // command queue
  abdf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .cmd_i   (fr_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // back: result word generation
  abdf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_cmd),
    .cmd_pop_o       (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .first_of_unit_o (first_of_unit_o),
    .unit_length_o   (unit_length_o),
    .last_of_run_o   (last_of_run_o)
  );

  // shorthand for the checks below
  assign out_payload = !empty && kind_o == KIND_PAYLOAD;
  assign end_popped  = pop && !empty && kind_o == KIND_UNIT_END;

  // an error word always stands alone for its byte
  `ABDF_ASSERT_IMP(a_err_alone, !empty && kind_o == KIND_ERROR, last_of_run_o)
  // payload words carry no length
  `ABDF_ASSERT_IMP(a_payload_no_len, out_payload, unit_length_o == 32'd0)
  // a payload word right after a unit end opens a new unit
  `ABDF_ASSERT_NXT(a_first_after_end, end_popped, !out_payload || first_of_unit_o)

endmodule

// ===== rtl/abdf_front.sv =====
// front end: start code state machine, turns each accepted byte into at most one command
module abdf_front import abdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       stream_end_i,
  output logic       cmd_valid_o,
  output abdf_cmd_t  cmd_o
);

  localparam logic [1:0] PH_SEEK  = 2'd0;
  localparam logic [1:0] PH_UNIT  = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;
  localparam logic [1:0] PH_ERR   = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [1:0] held_q, held_d;
  logic [1:0] zeros;
  logic       has_byte;
  logic [1:0] ends;
  logic       err;
  logic       is_zero;
  logic       is_one;

  assign is_zero = (data_byte_i == 8'h00);
  assign is_one  = (data_byte_i == 8'h01);

  // classify the byte against the current phase
  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    zeros    = 2'd0;
    has_byte = 1'b0;
    ends     = 2'd0;
    err      = 1'b0;
    unique case (phase_q)
      PH_SEEK: begin
        if (is_zero) begin
          if (!held_q[1]) held_d = held_q + 2'd1;
        end else if (is_one && held_q[1]) begin
          phase_d = PH_UNIT;
          held_d  = 2'd0;
        end else begin
          err     = 1'b1;
          phase_d = PH_ERR;
        end
      end
      PH_UNIT: begin
        if (is_zero) begin
          if (!held_q[1]) begin
            held_d = held_q + 2'd1;
          end else begin
            ends    = 2'd1;
            phase_d = PH_TRAIL;
            held_d  = 2'd0;
          end
        end else if (is_one && held_q[1]) begin
          ends   = 2'd1;
          held_d = 2'd0;
        end else begin
          zeros    = held_q;
          has_byte = 1'b1;
          held_d   = 2'd0;
        end
      end
      PH_TRAIL: begin
        if (is_one) begin
          phase_d = PH_UNIT;
          held_d  = 2'd0;
        end else if (!is_zero) begin
          err     = 1'b1;
          phase_d = PH_ERR;
        end
      end
      default: begin
      end
    endcase
    // end of stream: in a unit flush held zeros and close it, in seek flag an error; return to seek
    if (stream_end_i) begin
      if (phase_d == PH_SEEK) begin
        err = 1'b1;
      end else if (phase_d == PH_UNIT) begin
        zeros = zeros | held_d;
        ends  = ends + 2'd1;
      end
      phase_d = PH_SEEK;
      held_d  = 2'd0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      held_q  <= 2'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  assign cmd_o.zeros    = zeros;
  assign cmd_o.has_byte = has_byte;
  assign cmd_o.data     = data_byte_i;
  assign cmd_o.ends     = ends;
  assign cmd_o.err      = err;
  assign cmd_valid_o    = accept_i && ((zeros != 2'd0) || has_byte || (ends != 2'd0) || err);

endmodule

// ===== rtl/abdf_cmd_fifo.sv =====
// short command queue between front and back
module abdf_cmd_fifo import abdf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  abdf_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output abdf_cmd_t cmd_o
);

  abdf_cmd_t              mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wr_ptr_q;
  logic [CMD_PTR_W-1:0]   rd_ptr_q;
  logic [CMD_PTR_W:0]     cnt_q;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = (cnt_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + (CMD_PTR_W + 1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (CMD_PTR_W + 1)'(1);
    end
  end

endmodule

// ===== rtl/abdf_back.sv =====
// back end: expands commands into result words, keeps unit length and first mark
module abdf_back import abdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  abdf_cmd_t   cmd_i,
  output logic        cmd_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        first_of_unit_o,
  output logic [31:0] unit_length_o,
  output logic        last_of_run_o
);

  logic [1:0]  step_q;
  logic [31:0] count_q;
  logic        first_q;
  logic        out_valid_q;
  kind_e       kind_q;
  logic [7:0]  byte_q;
  logic        first_out_q;
  logic [31:0] len_q;
  logic        last_q;

  logic [2:0]  total;
  logic [2:0]  thr_zero;
  logic [2:0]  thr_byte;
  logic [2:0]  step_w;
  logic        emit;
  logic        last;
  kind_e       kind_d;
  logic [7:0]  byte_d;

  // position of the current step inside the command
  assign thr_zero = {1'b0, cmd_i.zeros};
  assign thr_byte = thr_zero + {2'b0, cmd_i.has_byte};
  assign total    = thr_byte + {1'b0, cmd_i.ends} + {2'b0, cmd_i.err};
  assign step_w   = {1'b0, step_q};
  assign last     = (step_w == total - 3'd1);
  assign emit     = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = emit && last;

  // pick the result for this step
  always_comb begin
    byte_d = 8'h00;
    if (cmd_i.err) begin
      kind_d = KIND_ERROR;
    end else if (step_w < thr_zero) begin
      kind_d = KIND_PAYLOAD;
    end else if (step_w < thr_byte) begin
      kind_d = KIND_PAYLOAD;
      byte_d = cmd_i.data;
    end else begin
      kind_d = KIND_UNIT_END;
    end
  end

  // step counter, length counter and first mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 2'd0;
      count_q     <= 32'd0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        step_q <= last ? 2'd0 : step_q + 2'd1;
        if (kind_d == KIND_PAYLOAD) begin
          first_q <= 1'b0;
          if (count_q < LEN_MAX) count_q <= count_q + 32'd1;
        end else if (kind_d == KIND_UNIT_END) begin
          first_q <= 1'b1;
          count_q <= 32'd0;
        end
      end
      out_valid_q <= emit || (out_valid_q && !pop_i);
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q      <= kind_d;
      byte_q      <= byte_d;
      first_out_q <= (kind_d == KIND_PAYLOAD) && first_q;
      len_q       <= (kind_d == KIND_UNIT_END) ? count_q : 32'd0;
      last_q      <= last;
    end
  end

  assign empty_o         = !out_valid_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = byte_q;
  assign first_of_unit_o = first_out_q;
  assign unit_length_o   = len_q;
  assign last_of_run_o   = last_q;

endmodule
